[src/s8bsp_pkg.sv]
// ----------------------------------------------------------------------------
// s8bsp_pkg
// Shared types, constants and selector tables of the Simple8b stream packer.
// ----------------------------------------------------------------------------
`default_nettype none

package s8bsp_pkg;

  localparam int VALUE_W  = 60;
  localparam int WORD_W   = 64;
  localparam int SEL_W    = 4;
  localparam int NUM_SEL  = 16;
  localparam int IDX_W    = 8;
  localparam int OFF_W    = 6;
  localparam int SCAN_MAX = 240;

  localparam logic [SEL_W-1:0] SEL_FALLBACK = 4'd15;

  // Values per block for each selector.
  function automatic logic [IDX_W-1:0] sel_count(input logic [SEL_W-1:0] s);
    logic [IDX_W-1:0] n;
    unique case (s)
      4'd0:    n = 8'd240;
      4'd1:    n = 8'd120;
      4'd2:    n = 8'd60;
      4'd3:    n = 8'd30;
      4'd4:    n = 8'd20;
      4'd5:    n = 8'd15;
      4'd6:    n = 8'd12;
      4'd7:    n = 8'd10;
      4'd8:    n = 8'd8;
      4'd9:    n = 8'd7;
      4'd10:   n = 8'd6;
      4'd11:   n = 8'd5;
      4'd12:   n = 8'd4;
      4'd13:   n = 8'd3;
      4'd14:   n = 8'd2;
      default: n = 8'd1;
    endcase
    return n;
  endfunction

  // Bits per value for each selector; zero means a run of ones.
  function automatic logic [OFF_W-1:0] sel_width(input logic [SEL_W-1:0] s);
    logic [OFF_W-1:0] w;
    unique case (s)
      4'd0:    w = 6'd0;
      4'd1:    w = 6'd0;
      4'd2:    w = 6'd1;
      4'd3:    w = 6'd2;
      4'd4:    w = 6'd3;
      4'd5:    w = 6'd4;
      4'd6:    w = 6'd5;
      4'd7:    w = 6'd6;
      4'd8:    w = 6'd7;
      4'd9:    w = 6'd8;
      4'd10:   w = 6'd10;
      4'd11:   w = 6'd12;
      4'd12:   w = 6'd15;
      4'd13:   w = 6'd20;
      4'd14:   w = 6'd30;
      default: w = 6'd60;
    endcase
    return w;
  endfunction

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SCAN   = 6'b000010,
    ST_DECIDE = 6'b000100,
    ST_PACK   = 6'b001000,
    ST_COMMIT = 6'b010000,
    ST_EMIT   = 6'b100000
  } state_t;

  typedef struct packed {
    logic             clear;
    logic             update;
    logic [IDX_W-1:0] idx;
  } eval_ctl_t;

endpackage

`default_nettype wire

[src/s8bsp_ram.sv]
// ----------------------------------------------------------------------------
// s8bsp_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module s8bsp_ram #(
  parameter int WIDTH = 60,
  parameter int DEPTH = 256
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire [$clog2(DEPTH)-1:0]  waddr,
  input  wire [WIDTH-1:0]          wdata,
  input  wire                      re,
  input  wire [$clog2(DEPTH)-1:0]  raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[src/s8bsp_eval.sv]
// ----------------------------------------------------------------------------
// s8bsp_eval
// Per-selector fit flags over a scan of the buffer and greedy selector choice.
// ----------------------------------------------------------------------------
`default_nettype none

module s8bsp_eval #(
  parameter int CW = 9
) (
  input  wire                                   clk,
  input  wire s8bsp_pkg::eval_ctl_t             ctl,
  input  wire [s8bsp_pkg::VALUE_W-1:0]          data,
  input  wire [CW-1:0]                          limit,
  output logic [s8bsp_pkg::NUM_SEL-1:0]         ok_r,
  output logic [s8bsp_pkg::SEL_W-1:0]           sel
);

  logic [s8bsp_pkg::NUM_SEL-1:0] ok_nxt;

  // Fold one scanned value into the flag of each selector whose block covers its index
  always_comb begin
    logic [s8bsp_pkg::OFF_W-1:0]   w;
    logic [s8bsp_pkg::VALUE_W-1:0] hi_mask;
    logic                          cond;
    ok_nxt = ok_r;
    for (int s = 0; s < s8bsp_pkg::NUM_SEL; s++) begin
      w = s8bsp_pkg::sel_width(s8bsp_pkg::SEL_W'(s));
      hi_mask = ~((s8bsp_pkg::VALUE_W'(1) << w) - s8bsp_pkg::VALUE_W'(1));
      if (w == s8bsp_pkg::OFF_W'(0)) begin
        cond = (data == s8bsp_pkg::VALUE_W'(1));
      end else begin
        cond = ((data & hi_mask) == '0) || (w == s8bsp_pkg::OFF_W'(s8bsp_pkg::VALUE_W));
      end
      if (ctl.idx < s8bsp_pkg::sel_count(s8bsp_pkg::SEL_W'(s))) begin
        ok_nxt[s] = ok_r[s] & cond;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      ok_r <= '1;
    end else if (ctl.update) begin
      ok_r <= ok_nxt;
    end
  end

  // Pick the first selector whose block fits within the limit
  always_comb begin
    sel = s8bsp_pkg::SEL_FALLBACK;
    for (int s = s8bsp_pkg::NUM_SEL - 1; s >= 0; s--) begin
      if (ok_r[s] && (CW'(s8bsp_pkg::sel_count(s8bsp_pkg::SEL_W'(s))) <= limit)) begin
        sel = s8bsp_pkg::SEL_W'(s);
      end
    end
  end

endmodule

`default_nettype wire

[src/simple8b_stream_packer_unit.sv]
// ----------------------------------------------------------------------------
// simple8b_stream_packer_unit
// Buffers 60-bit values in a circular RAM and emits greedy Simple8b words.
// ----------------------------------------------------------------------------
// Sequence: a plain append writes the RAM from idle; a checkpoint or drain word
//   passes ST_SCAN (L = min(fill, 240) scan reads), ST_DECIDE, ST_PACK (n packed
//   reads, skipped for runs of ones), ST_COMMIT and ST_EMIT; a checkpoint that
//   packs nothing returns to idle after ST_DECIDE. Requests are taken one at a
//   time, paced by the single RAM read port that serves the scan and the pack passes.
// Reset: synchronous active-low rst_n empties the buffer; RAM is not cleared.
`default_nettype none

module simple8b_stream_packer_unit #(
  parameter int BUFFER_DEPTH = 256
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 in_valid,
  output logic                                in_stall,
  input  wire                                 in_command,
  input  wire [s8bsp_pkg::VALUE_W-1:0]        in_value,
  output logic                                out_valid,
  input  wire                                 out_stall,
  output logic [s8bsp_pkg::WORD_W-1:0]        out_packed_word,
  output logic                                out_buffer_empty
);

  localparam int AW = $clog2(BUFFER_DEPTH);
  localparam int CW = $clog2(BUFFER_DEPTH + 1);
  localparam int IW = s8bsp_pkg::IDX_W;

  s8bsp_pkg::state_t state_r, state_nxt;

  logic [AW-1:0]                   head_r, head_nxt;
  logic [CW-1:0]                   count_r, count_nxt;
  logic [CW-1:0]                   limit_r, limit_nxt;
  logic [IW-1:0]                   len_r, len_nxt;
  logic [IW-1:0]                   iss_r, iss_nxt;
  logic [IW-1:0]                   rd_idx_r;
  logic                            rd_vld_r;
  logic                            ckpt_r, ckpt_nxt;
  logic [s8bsp_pkg::SEL_W-1:0]     ck_sel_r, ck_sel_nxt;
  logic [s8bsp_pkg::SEL_W-1:0]     sel_r, sel_nxt;
  logic                            pend_r, pend_nxt;
  logic [s8bsp_pkg::VALUE_W-1:0]   val_r, val_nxt;
  logic [s8bsp_pkg::WORD_W-1:0]    word_r, word_nxt;
  logic [s8bsp_pkg::OFF_W-1:0]     off_r, off_nxt;
  logic                            out_valid_r;
  logic [s8bsp_pkg::WORD_W-1:0]    out_word_r;
  logic                            out_empty_r;

  logic                            ram_we, ram_re;
  logic [AW-1:0]                   ram_waddr, ram_raddr;
  logic [s8bsp_pkg::VALUE_W-1:0]   ram_wdata, ram_rdata;

  s8bsp_pkg::eval_ctl_t            ev_ctl;
  logic [s8bsp_pkg::NUM_SEL-1:0]   ev_ok;
  logic [s8bsp_pkg::SEL_W-1:0]     ev_sel;

  logic                            accept;
  logic                            out_free;
  logic                            last_rd;

  // Circular address: base plus offset, wrapped once
  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [CW-1:0] b);
    logic [AW:0] s;
    s = (AW+1)'(a) + (AW+1)'(b);
    if (s >= (AW+1)'(BUFFER_DEPTH)) begin
      s = s - (AW+1)'(BUFFER_DEPTH);
    end
    return s[AW-1:0];
  endfunction

  s8bsp_ram #(
    .WIDTH(s8bsp_pkg::VALUE_W),
    .DEPTH(BUFFER_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  s8bsp_eval #(
    .CW(CW)
  ) u_eval (
    .clk   (clk),
    .ctl   (ev_ctl),
    .data  (ram_rdata),
    .limit (limit_r),
    .ok_r  (ev_ok),
    .sel   (ev_sel)
  );

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign last_rd  = rd_vld_r && (rd_idx_r == len_r - IW'(1));
  assign in_stall = (state_r != s8bsp_pkg::ST_IDLE);

  assign out_valid        = out_valid_r;
  assign out_packed_word  = out_word_r;
  assign out_buffer_empty = out_empty_r;

  // Sequencer: append, or scan, choose, pack, retire, emit
  always_comb begin
    logic [CW-1:0]               cnt_new;
    logic [s8bsp_pkg::OFF_W-1:0] w;
    state_nxt  = state_r;
    head_nxt   = head_r;
    count_nxt  = count_r;
    limit_nxt  = limit_r;
    len_nxt    = len_r;
    iss_nxt    = iss_r;
    ckpt_nxt   = ckpt_r;
    ck_sel_nxt = ck_sel_r;
    sel_nxt    = sel_r;
    pend_nxt   = pend_r;
    val_nxt    = val_r;
    word_nxt   = word_r;
    off_nxt    = off_r;
    ram_we     = 1'b0;
    ram_waddr  = wrap_add(head_r, count_r);
    ram_wdata  = in_value;
    ram_re     = 1'b0;
    ram_raddr  = wrap_add(head_r, CW'(iss_r));
    ev_ctl.clear  = 1'b0;
    ev_ctl.update = 1'b0;
    ev_ctl.idx    = rd_idx_r;
    cnt_new    = count_r + CW'(1);
    w          = s8bsp_pkg::sel_width(sel_r);

    unique case (state_r)
      s8bsp_pkg::ST_IDLE: begin
        if (accept) begin
          iss_nxt  = '0;
          ckpt_nxt = 1'b0;
          pend_nxt = 1'b0;
          val_nxt  = in_value;
          if (in_command) begin
            // Drain: one greedy block from the head of the buffer
            if (count_r != '0) begin
              limit_nxt    = count_r;
              len_nxt      = (count_r > CW'(s8bsp_pkg::SCAN_MAX)) ?
                             IW'(s8bsp_pkg::SCAN_MAX) : count_r[IW-1:0];
              ev_ctl.clear = 1'b1;
              state_nxt    = s8bsp_pkg::ST_SCAN;
            end
          end else if (count_r == CW'(BUFFER_DEPTH)) begin
            // Full buffer: emit first, append after
            pend_nxt     = 1'b1;
            limit_nxt    = count_r;
            len_nxt      = IW'(s8bsp_pkg::SCAN_MAX);
            ev_ctl.clear = 1'b1;
            state_nxt    = s8bsp_pkg::ST_SCAN;
          end else begin
            // Append, then check for a checkpoint count
            ram_we    = 1'b1;
            count_nxt = cnt_new;
            for (int s = 0; s < s8bsp_pkg::NUM_SEL; s++) begin
              if (cnt_new == CW'(s8bsp_pkg::sel_count(s8bsp_pkg::SEL_W'(s)))) begin
                ck_sel_nxt = s8bsp_pkg::SEL_W'(s);
              end
            end
            for (int s = 0; s < s8bsp_pkg::NUM_SEL; s++) begin
              if (cnt_new == CW'(s8bsp_pkg::sel_count(s8bsp_pkg::SEL_W'(s))) &&
                  cnt_new > CW'(1)) begin
                ckpt_nxt     = 1'b1;
                limit_nxt    = count_r;
                len_nxt      = cnt_new[IW-1:0];
                ev_ctl.clear = 1'b1;
                state_nxt    = s8bsp_pkg::ST_SCAN;
              end
            end
          end
        end
      end

      s8bsp_pkg::ST_SCAN: begin
        // Stream entries through the fit flags
        if (iss_r < len_r) begin
          ram_re  = 1'b1;
          iss_nxt = iss_r + IW'(1);
        end
        ev_ctl.update = rd_vld_r;
        if (last_rd) begin
          state_nxt = s8bsp_pkg::ST_DECIDE;
        end
      end

      s8bsp_pkg::ST_DECIDE: begin
        iss_nxt  = '0;
        off_nxt  = '0;
        sel_nxt  = ev_sel;
        word_nxt = {ev_sel, {(s8bsp_pkg::WORD_W - s8bsp_pkg::SEL_W){1'b0}}};
        len_nxt  = s8bsp_pkg::sel_count(ev_sel);
        if (ckpt_r && ev_ok[ck_sel_r]) begin
          state_nxt = s8bsp_pkg::ST_IDLE;
        end else if (s8bsp_pkg::sel_width(ev_sel) == '0) begin
          state_nxt = s8bsp_pkg::ST_COMMIT;
        end else begin
          state_nxt = s8bsp_pkg::ST_PACK;
        end
      end

      s8bsp_pkg::ST_PACK: begin
        // Shift each value into place
        if (iss_r < len_r) begin
          ram_re  = 1'b1;
          iss_nxt = iss_r + IW'(1);
        end
        if (rd_vld_r) begin
          word_nxt = word_r | (s8bsp_pkg::WORD_W'(ram_rdata) << off_r);
          off_nxt  = off_r + w;
        end
        if (last_rd) begin
          state_nxt = s8bsp_pkg::ST_COMMIT;
        end
      end

      s8bsp_pkg::ST_COMMIT: begin
        // Drop the packed values from the head
        head_nxt  = wrap_add(head_r, CW'(len_r));
        count_nxt = count_r - CW'(len_r);
        state_nxt = s8bsp_pkg::ST_EMIT;
      end

      s8bsp_pkg::ST_EMIT: begin
        if (out_free) begin
          if (pend_r) begin
            ram_we    = 1'b1;
            ram_wdata = val_r;
            count_nxt = cnt_new;
          end
          state_nxt = s8bsp_pkg::ST_IDLE;
        end
      end

      default: state_nxt = s8bsp_pkg::ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= s8bsp_pkg::ST_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      head_r   <= head_nxt;
      count_r  <= count_nxt;
      rd_vld_r <= ram_re;
      if (state_r == s8bsp_pkg::ST_EMIT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    limit_r  <= limit_nxt;
    len_r    <= len_nxt;
    iss_r    <= iss_nxt;
    rd_idx_r <= iss_r;
    ckpt_r   <= ckpt_nxt;
    ck_sel_r <= ck_sel_nxt;
    sel_r    <= sel_nxt;
    pend_r   <= pend_nxt;
    val_r    <= val_nxt;
    word_r   <= word_nxt;
    off_r    <= off_nxt;
    if (state_r == s8bsp_pkg::ST_EMIT && out_free) begin
      out_word_r  <= word_r;
      out_empty_r <= (count_r == '0) && !pend_r;
    end
  end

endmodule

`default_nettype wire
